// ----- design/swql_pkg.sv -----
// Shared types, widths and codes for the sliding window quota limiter.
`timescale 1ns / 1ps

package swql_pkg;

  localparam int LOG_DEPTH = 64;

  localparam int STAMP_W   = 32;
  localparam int AMT_W     = 16;
  localparam int LIMIT_W   = 24;
  localparam int WINDOW_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W = AMT_W + $clog2(LOG_DEPTH);
  localparam int CMP_W = ((SUM_W > LIMIT_W) ? SUM_W : LIMIT_W) + 1;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(1);

  localparam logic [STATUS_W-1:0] STATUS_GRANTED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_OVER    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_FULL    = STATUS_W'(2);

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [AMT_W-1:0]   amount;
  } entry_t;

endpackage

// ----- design/swql_cell.sv -----
// One log cell: holds an entry, takes its neighbor's entry on a pop and loads a new entry on an append.
`timescale 1ns / 1ps

module swql_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  swql_pkg::entry_t next_i,
  input  swql_pkg::entry_t new_i,
  output swql_pkg::entry_t entry_o
);
  import swql_pkg::*;

  entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = next_i;
    end else if (load_i) begin
      entry_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- design/sliding_window_quota_limiter_unit.sv -----
// Top level of the sliding window quota limiter: control, running sum and cell chain.
// Flow: a taken request enters the expire state, where the head cell is checked and popped
// once a cycle while it holds an expired entry, then the decide state; done is registered from it.
// Busy stays high in the expire and decide states; a new request is taken only while idle.
// The receiver cannot stall: done is a one-cycle strobe with status and window total.
// Reset empties the log and clears both configuration registers; no clearing pass.
`timescale 1ns / 1ps

module sliding_window_quota_limiter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [swql_pkg::STAMP_W-1:0]      now_seconds_i,
  input  logic [swql_pkg::AMT_W-1:0]        request_amount_i,
  output logic                              done_o,
  output logic [swql_pkg::STATUS_W-1:0]     status_o,
  output logic [swql_pkg::TOTAL_W-1:0]      window_total_o,
  input  logic                              cfg_we_i,
  input  logic [swql_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [swql_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import swql_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPIRE = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]          state_d, state_q;
  logic [STAMP_W-1:0]  now_q;
  logic [AMT_W-1:0]    amt_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [WINDOW_W-1:0] window_q;
  logic [CNT_W-1:0]    count_d, count_q;
  logic [SUM_W-1:0]    sum_d, sum_q;
  logic                done_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [TOTAL_W-1:0]  total_q;

  entry_t              cells [LOG_DEPTH];
  entry_t              new_entry;
  logic [STAMP_W-1:0]  age;
  logic                expired, pop, over, full, append, accept;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign new_entry = '{stamp: now_q, amount: amt_q};

  // The oldest entry always sits in the first cell.
  assign age     = now_q - cells[0].stamp;
  assign expired = (count_q != '0) && (age > STAMP_W'(window_q));
  assign pop     = (state_q == ST_EXPIRE) && expired;
  assign over    = (CMP_W'(sum_q) + CMP_W'(amt_q)) > CMP_W'(limit_q);
  assign full    = (count_q >= CNT_W'(LOG_DEPTH));
  assign append  = (state_q == ST_DECIDE) && !over && !full;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    entry_t next_entry;
    if (i == LOG_DEPTH - 1) begin : g_last
      assign next_entry = cells[i];
    end else begin : g_mid
      assign next_entry = cells[i+1];
    end
    swql_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (pop),
      .load_i  (append && (count_q == CNT_W'(i))),
      .next_i  (next_entry),
      .new_i   (new_entry),
      .entry_o (cells[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sum_d    = sum_q;
    status_d = STATUS_GRANTED;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (expired) begin
          count_d = count_q - CNT_W'(1);
          sum_d   = sum_q - SUM_W'(cells[0].amount);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (over) begin
          status_d = STATUS_OVER;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
          sum_d   = sum_q + SUM_W'(amt_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      sum_q    <= '0;
      done_q   <= 1'b0;
      limit_q  <= '0;
      window_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= (state_q == ST_DECIDE);
      if (cfg_we_i && (cfg_idx_i == REG_LIMIT)) begin
        limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_WINDOW)) begin
        window_q <= cfg_wdata_i[WINDOW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_seconds_i;
      amt_q <= request_amount_i;
    end
    if (state_q == ST_DECIDE) begin
      status_q <= status_d;
      total_q  <= TOTAL_W'(sum_d);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign window_total_o = total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LOG_DEPTH))
    else $error("entry count above log depth");

  a_done_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |=> done_o)
    else $error("missing result strobe after decision");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (count_q == CNT_W'($past(count_q) - CNT_W'(1))))
    else $error("pop did not shorten the log");

  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    append |=> (count_q == CNT_W'($past(count_q) + CNT_W'(1))) && (status_o == STATUS_GRANTED))
    else $error("granted request not logged");

endmodule
